// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  // Store geometry and cursor limits
  localparam int STORE_CELLS = 4096;
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;

  localparam int ADDR_W = $clog2(STORE_CELLS);
  localparam int COL_W  = 8;
  localparam int ROW_W  = 6;
  localparam int CUR_W  = 13;
  localparam int IDX_W  = 12;
  // Linear index: row times columns plus column, before masking
  localparam int LIN_W  = ROW_W + COL_W;

  // Character codes
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 2'd2;

  // Configuration reset values
  localparam logic [COL_W-1:0] COLUMNS_RST    = 8'd80;
  localparam logic [ROW_W-1:0] ROWS_RST       = 6'd25;
  localparam logic [7:0]       TEXT_COLOR_RST = 8'd7;

  typedef struct packed {
    logic [7:0] letter;
    logic [7:0] color;
  } tcw_cell_t;

  typedef struct packed {
    logic              letter_we;
    logic              color_we;
    logic [ADDR_W-1:0] addr;
    tcw_cell_t         data;
  } tcw_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } tcw_rd_t;

endpackage

// ===== src/tcw_cell_store.sv =====
module tcw_cell_store (
  input  logic              clk_i,
  input  tcw_pkg::tcw_wr_t  wr_i,
  input  tcw_pkg::tcw_rd_t  rd_i,
  output tcw_pkg::tcw_cell_t rdata_o
);

  logic [7:0] letter_mem [tcw_pkg::STORE_CELLS];
  logic [7:0] color_mem  [tcw_pkg::STORE_CELLS];
  tcw_pkg::tcw_cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.letter_we) begin
      letter_mem[wr_i.addr] <= wr_i.data.letter;
    end
    if (rd_i.re) begin
      rdata_q.letter <= letter_mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.color_we) begin
      color_mem[wr_i.addr] <= wr_i.data.color;
    end
    if (rd_i.re) begin
      rdata_q.color <= color_mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/text_console_writer_unit.sv =====
// Text console writer. Each input transaction is either a character put or a
// one-cell read, and each yields exactly one output transaction carrying the
// linear cursor index (row * columns + column) and, for a read, the letter and
// color bytes of the addressed cell. Letters and colors sit in two synchronous
// stores of 4096 entries, each with one read and one write port. After reset
// the block runs a clearing pass (one cell per cycle) over all 4096 cells
// before it takes its first item; configuration writes are taken throughout.
// A read, a newline or a carriage return passes through the execute and
// response states; a backspace passes through execute, index and tail (at
// column 0 it goes straight to response, and nothing changes); a printable
// character passes through execute, index, put and tail. A character that
// scrolls the screen first moves or blanks every cell of the screen, one per
// cycle, and input stalls meanwhile. A finished result waits in an output
// register, so the next item may be accepted while it is pending.
module text_console_writer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [7:0]                            cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  in_op_i,
  input  logic [7:0]                            in_ch_i,
  input  logic [tcw_pkg::IDX_W-1:0]             in_cell_index_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tcw_pkg::CUR_W-1:0]             out_cursor_index_o,
  output logic [7:0]                            out_cell_letter_o,
  output logic [7:0]                            out_cell_color_o
);

  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int LIN_W  = tcw_pkg::LIN_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SC_SETUP,
    ST_SCROLL,
    ST_INDEX,
    ST_PUT,
    ST_TAIL,
    ST_RESP
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic [COL_W-1:0]         columns_q, columns_d;
  logic [ROW_W-1:0]         rows_q, rows_d;
  logic [7:0]               color_q, color_d;
  logic [COL_W-1:0]         col_q, col_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic                     op_q, op_d;
  logic [7:0]               ch_q, ch_d;
  logic [tcw_pkg::IDX_W-1:0] cidx_q, cidx_d;
  logic                     hit_q, hit_d;
  logic [LIN_W-1:0]         lin_q, lin_d;
  logic [LIN_W-1:0]         sc_q, sc_d;
  logic [LIN_W-1:0]         sc_end_q, sc_end_d;
  logic                     p_we_q, p_we_d;
  logic                     p_copy_q, p_copy_d;
  logic [ADDR_W-1:0]        p_dst_q, p_dst_d;
  logic                     out_valid_q, out_valid_d;
  logic [tcw_pkg::CUR_W-1:0] out_cursor_q, out_cursor_d;
  logic [7:0]               out_letter_q, out_letter_d;
  logic [7:0]               out_color_q, out_color_d;

  logic [COL_W-1:0]   eff_cols;
  logic [ROW_W-1:0]   eff_rows;
  logic [LIN_W-1:0]   row_base;
  logic [LIN_W-1:0]   cur_lin;
  logic [LIN_W-1:0]   lin_next;
  logic [LIN_W-1:0]   sc_total;
  logic [LIN_W-1:0]   sc_src;
  logic               sc_copy;
  logic [ROW_W-1:0]   row_inc;
  logic               wrap;
  logic [ROW_W-1:0]   wrap_row;
  logic               out_free;

  tcw_pkg::tcw_wr_t   wr;
  tcw_pkg::tcw_rd_t   rd;
  tcw_pkg::tcw_cell_t rdata;

  tcw_cell_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  // Out-of-range geometry settings clamp into the supported range
  always_comb begin
    if (columns_q == '0) begin
      eff_cols = COL_W'(1);
    end else if (columns_q > COL_W'(tcw_pkg::MAX_COLUMNS)) begin
      eff_cols = COL_W'(tcw_pkg::MAX_COLUMNS);
    end else begin
      eff_cols = columns_q;
    end
    if (rows_q == '0) begin
      eff_rows = ROW_W'(1);
    end else if (rows_q > ROW_W'(tcw_pkg::MAX_ROWS)) begin
      eff_rows = ROW_W'(tcw_pkg::MAX_ROWS);
    end else begin
      eff_rows = rows_q;
    end
  end

  // Single shared multiplier: cursor row times row width
  assign row_base = LIN_W'(row_q) * LIN_W'(eff_cols);
  assign cur_lin  = row_base + LIN_W'(col_q);
  assign lin_next = lin_q + LIN_W'(1);
  assign sc_total = sc_end_q + LIN_W'(eff_cols);
  assign sc_src   = sc_q + LIN_W'(eff_cols);
  assign sc_copy  = (sc_q < sc_end_q);

  assign row_inc  = (row_q >= eff_rows) ? eff_rows : row_q + ROW_W'(1);
  assign wrap     = (col_q >= eff_cols);
  assign wrap_row = wrap ? row_inc : row_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    columns_d    = columns_q;
    rows_d       = rows_q;
    color_d      = color_q;
    col_d        = col_q;
    row_d        = row_q;
    op_d         = op_q;
    ch_d         = ch_q;
    cidx_d       = cidx_q;
    hit_d        = hit_q;
    lin_d        = lin_q;
    sc_d         = sc_q;
    sc_end_d     = sc_end_q;
    p_we_d       = 1'b0;
    p_copy_d     = p_copy_q;
    p_dst_d      = p_dst_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_cursor_d = out_cursor_q;
    out_letter_d = out_letter_q;
    out_color_d  = out_color_q;
    wr           = '0;
    rd           = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tcw_pkg::REG_COLUMNS:    columns_d = cfg_data_i;
        tcw_pkg::REG_ROWS:       rows_d    = cfg_data_i[ROW_W-1:0];
        tcw_pkg::REG_TEXT_COLOR: color_d   = cfg_data_i;
        default: ;
      endcase
    end

    // Second stage of the scroll copy: write back what was read last cycle, or a blank
    if (p_we_q) begin
      wr.letter_we = 1'b1;
      wr.color_we  = 1'b1;
      wr.addr      = p_dst_q;
      if (p_copy_q) begin
        wr.data = rdata;
      end else begin
        wr.data.letter = tcw_pkg::CH_SPACE;
        wr.data.color  = '0;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        wr.letter_we   = 1'b1;
        wr.color_we    = 1'b1;
        wr.addr        = clr_q;
        wr.data.letter = tcw_pkg::CH_SPACE;
        wr.data.color  = '0;
        clr_d          = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op_i;
          ch_d    = in_ch_i;
          cidx_d  = in_cell_index_i;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        hit_d = 1'b0;
        if (op_q == tcw_pkg::OP_READ) begin
          if (LIN_W'(cidx_q) < LIN_W'(tcw_pkg::STORE_CELLS)) begin
            hit_d   = 1'b1;
            rd.re   = 1'b1;
            rd.addr = cidx_q[ADDR_W-1:0];
          end
          state_d = ST_RESP;
        end else if (ch_q == tcw_pkg::CH_NEWLINE) begin
          row_d   = row_inc;
          col_d   = '0;
          state_d = ST_RESP;
        end else if (ch_q == tcw_pkg::CH_RETURN) begin
          col_d   = '0;
          state_d = ST_RESP;
        end else if (ch_q == tcw_pkg::CH_BACKSPACE) begin
          if (col_q == '0) begin
            state_d = ST_RESP;
          end else begin
            col_d   = col_q - COL_W'(1);
            state_d = ST_INDEX;
          end
        end else begin
          if (wrap) begin
            col_d = '0;
          end
          if (wrap_row >= eff_rows) begin
            row_d   = eff_rows - ROW_W'(1);
            state_d = ST_SC_SETUP;
          end else begin
            row_d   = wrap_row;
            state_d = ST_INDEX;
          end
        end
      end

      ST_SC_SETUP: begin
        // row already sits on the last row, so row_base marks its start
        sc_end_d = row_base;
        sc_d     = '0;
        state_d  = ST_SCROLL;
      end

      ST_SCROLL: begin
        if (sc_q != sc_total) begin
          p_copy_d = sc_copy;
          p_dst_d  = sc_q[ADDR_W-1:0];
          p_we_d   = (sc_q < LIN_W'(tcw_pkg::STORE_CELLS)) &&
                     (!sc_copy || (sc_src < LIN_W'(tcw_pkg::STORE_CELLS)));
          if (sc_copy && (sc_src < LIN_W'(tcw_pkg::STORE_CELLS))) begin
            rd.re   = 1'b1;
            rd.addr = sc_src[ADDR_W-1:0];
          end
          sc_d = sc_q + LIN_W'(1);
        end else begin
          state_d = ST_INDEX;
        end
      end

      ST_INDEX: begin
        lin_d   = cur_lin;
        state_d = (ch_q == tcw_pkg::CH_BACKSPACE) ? ST_TAIL : ST_PUT;
      end

      ST_PUT: begin
        if (lin_q < LIN_W'(tcw_pkg::STORE_CELLS)) begin
          wr.letter_we   = 1'b1;
          wr.color_we    = 1'b1;
          wr.addr        = lin_q[ADDR_W-1:0];
          wr.data.letter = ch_q;
          wr.data.color  = color_q;
        end
        col_d   = col_q + COL_W'(1);
        state_d = ST_TAIL;
      end

      ST_TAIL: begin
        // Repeats harmlessly while the output register is still full
        if (ch_q == tcw_pkg::CH_BACKSPACE) begin
          if (lin_q < LIN_W'(tcw_pkg::STORE_CELLS)) begin
            wr.letter_we   = 1'b1;
            wr.addr        = lin_q[ADDR_W-1:0];
            wr.data.letter = '0;
          end
        end else if (lin_next < LIN_W'(tcw_pkg::STORE_CELLS)) begin
          wr.color_we   = 1'b1;
          wr.addr       = lin_next[ADDR_W-1:0];
          wr.data.color = color_q;
        end
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_cursor_d = cur_lin[tcw_pkg::CUR_W-1:0];
          out_letter_d = '0;
          out_color_d  = '0;
          state_d      = ST_IDLE;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_cursor_d = cur_lin[tcw_pkg::CUR_W-1:0];
          out_letter_d = hit_q ? rdata.letter : 8'd0;
          out_color_d  = hit_q ? rdata.color : 8'd0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      columns_q    <= tcw_pkg::COLUMNS_RST;
      rows_q       <= tcw_pkg::ROWS_RST;
      color_q      <= tcw_pkg::TEXT_COLOR_RST;
      col_q        <= '0;
      row_q        <= '0;
      op_q         <= tcw_pkg::OP_PUT;
      ch_q         <= '0;
      cidx_q       <= '0;
      hit_q        <= 1'b0;
      lin_q        <= '0;
      sc_q         <= '0;
      sc_end_q     <= '0;
      p_we_q       <= 1'b0;
      p_copy_q     <= 1'b0;
      p_dst_q      <= '0;
      out_valid_q  <= 1'b0;
      out_cursor_q <= '0;
      out_letter_q <= '0;
      out_color_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      columns_q    <= columns_d;
      rows_q       <= rows_d;
      color_q      <= color_d;
      col_q        <= col_d;
      row_q        <= row_d;
      op_q         <= op_d;
      ch_q         <= ch_d;
      cidx_q       <= cidx_d;
      hit_q        <= hit_d;
      lin_q        <= lin_d;
      sc_q         <= sc_d;
      sc_end_q     <= sc_end_d;
      p_we_q       <= p_we_d;
      p_copy_q     <= p_copy_d;
      p_dst_q      <= p_dst_d;
      out_valid_q  <= out_valid_d;
      out_cursor_q <= out_cursor_d;
      out_letter_q <= out_letter_d;
      out_color_q  <= out_color_d;
    end
  end

  assign cfg_ready_o        = 1'b1;
  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_cursor_index_o = out_cursor_q;
  assign out_cell_letter_o  = out_letter_q;
  assign out_cell_color_o   = out_color_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(tcw_pkg::MAX_COLUMNS))
    else $error("cursor column beyond the widest row");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !(wr.letter_we || wr.color_we) && !p_we_q)
    else $error("store written while idle");

  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we_q && rd.re |-> p_dst_q < rd.addr)
    else $error("scroll write overtook its read");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_TAIL || state_q == ST_RESP))
    else $error("result raised outside a finishing state");

  a_put_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUT |=> col_q == $past(col_q) + COL_W'(1))
    else $error("cursor did not advance after a put");

endmodule
